/* rtl/crtc_pkg.sv */
// ----------------------------------------------------------------------------
// crtc_pkg - CRT timing controller shared definitions
// Item codes, bus ports, chip variants, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package crtc_pkg;

  // Kind of work carried by one input beat.
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Bus port selected by a write or read beat.
  typedef enum logic [1:0] {
    PORT_INDEX  = 2'd0,
    PORT_DATA   = 2'd1,
    PORT_STATUS = 2'd2,
    PORT_RDATA  = 2'd3
  } port_e;

  // Chip variants.
  localparam logic [2:0] CT_HD    = 3'd0;
  localparam logic [2:0] CT_UM    = 3'd1;
  localparam logic [2:0] CT_MC    = 3'd2;
  localparam logic [2:0] CT_ASIC1 = 3'd3;
  localparam logic [2:0] CT_ASIC2 = 3'd4;

  // Register file indexes.
  localparam logic [7:0] REG_H_TOTAL   = 8'd0;
  localparam logic [7:0] REG_H_DISP    = 8'd1;
  localparam logic [7:0] REG_HSYNC_POS = 8'd2;
  localparam logic [7:0] REG_SYNC_WID  = 8'd3;
  localparam logic [7:0] REG_V_TOTAL   = 8'd4;
  localparam logic [7:0] REG_V_ADJUST  = 8'd5;
  localparam logic [7:0] REG_V_DISP    = 8'd6;
  localparam logic [7:0] REG_VSYNC_POS = 8'd7;
  localparam logic [7:0] REG_SKEW      = 8'd8;
  localparam logic [7:0] REG_MAX_RAST  = 8'd9;
  localparam logic [7:0] REG_START_HI  = 8'd12;
  localparam logic [7:0] REG_START_LO  = 8'd13;
  localparam logic [7:0] REG_CURS_HI   = 8'd14;
  localparam logic [7:0] REG_CURS_LO   = 8'd15;
  localparam logic [4:0] REG_FLOAT     = 5'd31;

  // Read map of the ASIC variants, selected by the low index bits.
  localparam logic [2:0] ASIC_RD_ID       = 3'd3;
  localparam logic [2:0] ASIC_RD_START_HI = 3'd4;
  localparam logic [2:0] ASIC_RD_START_LO = 3'd5;
  localparam logic [2:0] ASIC_RD_CURS_HI  = 3'd6;
  localparam logic [2:0] ASIC_RD_CURS_LO  = 3'd7;

  localparam logic [7:0] ASIC2_ID_BYTE = 8'h08;
  localparam logic [7:0] STATUS_VBLANK = 8'h20;
  localparam logic [7:0] FLOAT_BYTE    = 8'hFF;

  // Reset values.
  localparam logic [7:0]  RST_H_TOTAL     = 8'd63;
  localparam logic [7:0]  RST_H_DISP      = 8'd40;
  localparam logic [7:0]  RST_HSYNC_POS   = 8'd46;
  localparam logic [3:0]  RST_HSYNC_WIDTH = 4'd14;
  localparam logic [3:0]  RST_VSYNC_WIDTH = 4'd8;
  localparam logic [6:0]  RST_V_TOTAL     = 7'd38;
  localparam logic [6:0]  RST_V_DISP      = 7'd25;
  localparam logic [6:0]  RST_VSYNC_POS   = 7'd30;
  localparam logic [7:0]  RST_MAX_RAST    = 8'd7;
  localparam logic [13:0] RST_START_ADDR  = 14'h3000;

endpackage

`default_nettype wire

/* rtl/crt_timing_controller.sv */
// ----------------------------------------------------------------------------
// crt_timing_controller - 6845-style CRT timing controller
// Register file, character/raster/row counters, syncs and address generation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one beat per
//   operation: a character clock tick, a bus write to the index or data
//   port, or a bus read. Every accepted beat produces exactly one beat on
//   the output channel (out_valid_o / out_stall_i) holding the read data
//   (zero unless the beat was a read) and the video timing outputs as they
//   stand after that operation.
//   The result of a beat accepted at one edge is shown from the next
//   cycle on. Throughput is one beat per cycle while the receiver does
//   not stall; the whole tick update is a single pass of compare and
//   increment logic from the state registers back into themselves, and
//   the output register lets the next beat in while a result is taken.
//   When the receiver stalls, the pending result holds and in_stall_o
//   rises, so no state changes until the result is taken.
//   cfg_we_i writes the chip variant; it is meant to change only while the
//   block is idle.
//   Reset puts the register file at its power-on timing values, clears the
//   counters and leaves the output channel empty.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_timing_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [1:0]  port_i,
  input  wire logic [7:0]  wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       rdata_o,
  output logic [13:0]      mem_addr_o,
  output logic [4:0]       raster_addr_o,
  output logic             hsync_o,
  output logic             vsync_o,
  output logic             border_o
);

  logic in_accept;

  // Chip variant.
  logic [2:0] chip_type_q;

  // Register file.
  logic [7:0]  reg_index_q, reg_index_d;
  logic [7:0]  h_total_q, h_total_d;
  logic [7:0]  h_disp_q, h_disp_d;
  logic [7:0]  hsync_pos_q, hsync_pos_d;
  logic [3:0]  hsync_width_q, hsync_width_d;
  logic [3:0]  vsync_width_q, vsync_width_d;
  logic [6:0]  v_total_q, v_total_d;
  logic [4:0]  v_adjust_q, v_adjust_d;
  logic [6:0]  v_disp_q, v_disp_d;
  logic [6:0]  vsync_pos_q, vsync_pos_d;
  logic [7:0]  skew_q, skew_d;
  logic [7:0]  max_rast_q, max_rast_d;
  logic [13:0] start_q, start_d;
  logic [5:0]  curs_hi_q, curs_hi_d;
  logic [7:0]  curs_lo_q, curs_lo_d;

  // Counters and address generation.
  logic [13:0] addr_q, addr_d;
  logic [13:0] line_base_q, line_base_d;
  logic [4:0]  rast_q, rast_d;
  logic [7:0]  h_cnt_q, h_cnt_d;
  logic [6:0]  v_cnt_q, v_cnt_d;
  logic [3:0]  hs_cnt_q, hs_cnt_d;
  logic [3:0]  vs_cnt_q, vs_cnt_d;

  // Timing flags.
  logic hsync_q, hsync_d;
  logic vsync_q, vsync_d;
  logic hdisp_q, hdisp_d;
  logic vdisp_q, vdisp_d;
  logic border_q, border_d;
  logic end_scr_q, end_scr_d;
  logic end_row_q, end_row_d;
  logic will_adj_q, will_adj_d;
  logic adj_mode_q, adj_mode_d;
  logic v_fired_q, v_fired_d;

  // Result channel.
  logic       out_valid_q, out_valid_d;
  logic [7:0] rdata_q, rdata_d;

  // Variant decode.
  logic       is_asic;
  logic       sync_short;
  logic       skew_off;
  logic [7:0] read_byte;

  assign is_asic    = (chip_type_q == crtc_pkg::CT_ASIC1) || (chip_type_q == crtc_pkg::CT_ASIC2);
  // These variants end vertical sync on a 16-line count and can start it
  // one line into the pulse when the sync row begins mid-line.
  assign sync_short = (chip_type_q == crtc_pkg::CT_UM) || (chip_type_q == crtc_pkg::CT_MC);
  // Skew setting "display off" is honored only by some variants.
  assign skew_off   = (skew_q[7:6] == 2'b11) && ((chip_type_q == crtc_pkg::CT_HD) || is_asic);

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Bus read data. Reads leave the state untouched, so this is a plain
  // decode of the current registers.
  // --------------------------------------------------------------------------
  always_comb begin
    read_byte = 8'h00;
    if (is_asic) begin
      // The ASIC variants answer on any port from the low index bits.
      case (reg_index_q[2:0])
        crtc_pkg::ASIC_RD_ID: begin
          read_byte = (chip_type_q == crtc_pkg::CT_ASIC2) ? crtc_pkg::ASIC2_ID_BYTE : 8'h00;
        end
        crtc_pkg::ASIC_RD_START_HI: read_byte = {2'b00, start_q[13:8]};
        crtc_pkg::ASIC_RD_START_LO: read_byte = start_q[7:0];
        crtc_pkg::ASIC_RD_CURS_HI:  read_byte = {2'b00, curs_hi_q};
        crtc_pkg::ASIC_RD_CURS_LO:  read_byte = curs_lo_q;
        default:                    read_byte = 8'h00;
      endcase
    end else if (port_i == crtc_pkg::PORT_STATUS) begin
      // Only one variant drives a status byte; the others leave the bus
      // floating high.
      if (chip_type_q == crtc_pkg::CT_UM) begin
        read_byte = vdisp_q ? 8'h00 : crtc_pkg::STATUS_VBLANK;
      end else begin
        read_byte = crtc_pkg::FLOAT_BYTE;
      end
    end else if (port_i == crtc_pkg::PORT_RDATA) begin
      if (chip_type_q == crtc_pkg::CT_HD) begin
        case (reg_index_q[4:0])
          crtc_pkg::REG_START_HI[4:0]: read_byte = {2'b00, start_q[13:8]};
          crtc_pkg::REG_START_LO[4:0]: read_byte = start_q[7:0];
          crtc_pkg::REG_CURS_HI[4:0]:  read_byte = {2'b00, curs_hi_q};
          crtc_pkg::REG_CURS_LO[4:0]:  read_byte = curs_lo_q;
          default:                     read_byte = 8'h00;
        endcase
      end else if (chip_type_q == crtc_pkg::CT_UM) begin
        case (reg_index_q[4:0])
          crtc_pkg::REG_FLOAT:        read_byte = crtc_pkg::FLOAT_BYTE;
          crtc_pkg::REG_CURS_HI[4:0]: read_byte = {2'b00, curs_hi_q};
          crtc_pkg::REG_CURS_LO[4:0]: read_byte = curs_lo_q;
          default:                    read_byte = 8'h00;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next state. The tick path is evaluated in the same order as the timing
  // events happen within one character clock: address advance, end of
  // screen and adjust detection, end of line, horizontal sync, end of the
  // displayed line, vertical sync, end of the displayed rows and finally the border.
  // --------------------------------------------------------------------------
  always_comb begin
    logic       new_frame;
    logic [3:0] vs_end;

    new_frame     = 1'b0;
    vs_end        = 4'd0;

    reg_index_d   = reg_index_q;
    h_total_d     = h_total_q;
    h_disp_d      = h_disp_q;
    hsync_pos_d   = hsync_pos_q;
    hsync_width_d = hsync_width_q;
    vsync_width_d = vsync_width_q;
    v_total_d     = v_total_q;
    v_adjust_d    = v_adjust_q;
    v_disp_d      = v_disp_q;
    vsync_pos_d   = vsync_pos_q;
    skew_d        = skew_q;
    max_rast_d    = max_rast_q;
    start_d       = start_q;
    curs_hi_d     = curs_hi_q;
    curs_lo_d     = curs_lo_q;
    addr_d        = addr_q;
    line_base_d   = line_base_q;
    rast_d        = rast_q;
    h_cnt_d       = h_cnt_q;
    v_cnt_d       = v_cnt_q;
    hs_cnt_d      = hs_cnt_q;
    vs_cnt_d      = vs_cnt_q;
    hsync_d       = hsync_q;
    vsync_d       = vsync_q;
    hdisp_d       = hdisp_q;
    vdisp_d       = vdisp_q;
    border_d      = border_q;
    end_scr_d     = end_scr_q;
    end_row_d     = end_row_q;
    will_adj_d    = will_adj_q;
    adj_mode_d    = adj_mode_q;
    v_fired_d     = v_fired_q;
    rdata_d       = rdata_q;

    if (in_accept) begin
      rdata_d = 8'h00;
      case (func_i)
        crtc_pkg::FUNC_TICK: begin
          addr_d = addr_q + 14'd1;
          if (h_cnt_q == 8'd1) begin
            end_scr_d = (v_total_q == v_cnt_q);
          end
          if ((h_cnt_q == 8'd2) && ({3'b000, rast_q} == max_rast_q) &&
              (v_cnt_q == v_total_q) && (v_adjust_q != 5'd0)) begin
            will_adj_d = 1'b1;
          end

          if (h_cnt_q == h_total_q) begin
            // End of a scan line.
            addr_d  = line_base_q;
            h_cnt_d = 8'd0;
            if (h_disp_q != 8'd0) begin
              hdisp_d = 1'b1;
            end
            if (!end_scr_d) begin
              end_row_d = ({3'b000, rast_q} == max_rast_q);
            end

            if (vsync_q) begin
              vs_end   = sync_short ? 4'd0 : vsync_width_q;
              vs_cnt_d = vs_cnt_q + 4'd1;
              if (vs_cnt_d == vs_end) begin
                vsync_d  = 1'b0;
                vs_cnt_d = 4'd0;
              end
            end

            if (adj_mode_q) begin
              // Extra raster lines after the last row.
              rast_d = rast_q + 5'd1;
              if (rast_d == v_adjust_q) begin
                rast_d     = 5'd0;
                adj_mode_d = 1'b0;
                will_adj_d = 1'b0;
                new_frame  = 1'b1;
              end
            end else if (end_row_d) begin
              rast_d = 5'd0;
              if (end_scr_d) begin
                if (will_adj_d) begin
                  adj_mode_d = 1'b1;
                end else begin
                  new_frame = 1'b1;
                end
              end else begin
                v_cnt_d = v_cnt_q + 7'd1;
              end
            end else begin
              rast_d = rast_q + 5'd1;
            end

            if (new_frame) begin
              line_base_d = start_q;
              addr_d      = start_q;
              vdisp_d     = (v_disp_q != 7'd0);
              v_cnt_d     = 7'd0;
              v_fired_d   = 1'b0;
              if (is_asic) begin
                vsync_d  = 1'b0;
                vs_cnt_d = 4'd0;
              end
            end

            end_row_d = ({3'b000, rast_d} == max_rast_q);
          end else begin
            h_cnt_d = h_cnt_q + 8'd1;
          end

          // Horizontal sync. A zero width means 16 characters, except on
          // the variants that then give no pulse at all.
          if (h_cnt_d == hsync_pos_q) begin
            hs_cnt_d = 4'd0;
            if (hsync_width_q == 4'd0) begin
              hsync_d = !((chip_type_q == crtc_pkg::CT_HD) || (chip_type_q == crtc_pkg::CT_UM));
            end else begin
              hsync_d = 1'b1;
            end
          end
          if (hsync_d) begin
            if ((hsync_width_q != 4'd0) && (hs_cnt_d == hsync_width_q)) begin
              hsync_d = 1'b0;
            end else begin
              hs_cnt_d = hs_cnt_d + 4'd1;
              if ((hsync_width_q == 4'd0) && (hs_cnt_d == 4'd0)) begin
                hsync_d = 1'b0;
              end
            end
          end

          // End of the displayed part of the line; on the last raster of a
          // row the next row starts where this one stopped.
          if (h_cnt_d == h_disp_q) begin
            hdisp_d = 1'b0;
            if ({3'b000, rast_d} == max_rast_q) begin
              line_base_d = addr_d;
            end
          end

          // Vertical sync fires once per frame.
          if (!v_fired_d && (v_cnt_d == vsync_pos_q)) begin
            if (is_asic) begin
              if ((h_cnt_d == 8'd0) && (rast_d == 5'd0)) begin
                vsync_d   = 1'b1;
                vs_cnt_d  = 4'd0;
                v_fired_d = 1'b1;
              end
            end else begin
              vsync_d   = 1'b1;
              vs_cnt_d  = ((h_cnt_d != 8'd0) && sync_short) ? 4'd1 : 4'd0;
              v_fired_d = 1'b1;
            end
          end

          if (vdisp_d && (v_cnt_d == v_disp_q)) begin
            vdisp_d = 1'b0;
          end

          border_d = !hdisp_d || !vdisp_d || skew_off;
        end

        crtc_pkg::FUNC_WRITE: begin
          if (port_i == crtc_pkg::PORT_INDEX) begin
            reg_index_d = wdata_i;
          end else if (port_i == crtc_pkg::PORT_DATA) begin
            case (reg_index_q)
              crtc_pkg::REG_H_TOTAL:   h_total_d   = wdata_i;
              crtc_pkg::REG_H_DISP:    h_disp_d    = wdata_i;
              crtc_pkg::REG_HSYNC_POS: hsync_pos_d = wdata_i;
              crtc_pkg::REG_SYNC_WID: begin
                hsync_width_d = wdata_i[3:0];
                vsync_width_d = wdata_i[7:4];
              end
              crtc_pkg::REG_V_TOTAL:   v_total_d   = wdata_i[6:0];
              crtc_pkg::REG_V_ADJUST:  v_adjust_d  = wdata_i[4:0];
              crtc_pkg::REG_V_DISP:    v_disp_d    = wdata_i[6:0];
              crtc_pkg::REG_VSYNC_POS: vsync_pos_d = wdata_i[6:0];
              crtc_pkg::REG_SKEW:      skew_d      = wdata_i;
              crtc_pkg::REG_MAX_RAST:  max_rast_d  = wdata_i;
              crtc_pkg::REG_START_HI:  start_d     = {wdata_i[5:0], start_q[7:0]};
              crtc_pkg::REG_START_LO:  start_d     = {start_q[13:8], wdata_i};
              crtc_pkg::REG_CURS_HI:   curs_hi_d   = wdata_i[5:0];
              crtc_pkg::REG_CURS_LO:   curs_lo_d   = wdata_i;
              default: ;
            endcase
          end
        end

        crtc_pkg::FUNC_READ: rdata_d = read_byte;

        default: ;
      endcase
    end
  end

  assign out_valid_d = in_accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_type_q <= crtc_pkg::CT_HD;
    end else if (cfg_we_i) begin
      chip_type_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_index_q   <= 8'd0;
      h_total_q     <= crtc_pkg::RST_H_TOTAL;
      h_disp_q      <= crtc_pkg::RST_H_DISP;
      hsync_pos_q   <= crtc_pkg::RST_HSYNC_POS;
      hsync_width_q <= crtc_pkg::RST_HSYNC_WIDTH;
      vsync_width_q <= crtc_pkg::RST_VSYNC_WIDTH;
      v_total_q     <= crtc_pkg::RST_V_TOTAL;
      v_adjust_q    <= 5'd0;
      v_disp_q      <= crtc_pkg::RST_V_DISP;
      vsync_pos_q   <= crtc_pkg::RST_VSYNC_POS;
      skew_q        <= 8'd0;
      max_rast_q    <= crtc_pkg::RST_MAX_RAST;
      start_q       <= crtc_pkg::RST_START_ADDR;
      curs_hi_q     <= 6'd0;
      curs_lo_q     <= 8'd0;
      addr_q        <= crtc_pkg::RST_START_ADDR;
      line_base_q   <= crtc_pkg::RST_START_ADDR;
      rast_q        <= 5'd0;
      h_cnt_q       <= 8'd0;
      v_cnt_q       <= 7'd0;
      hs_cnt_q      <= 4'd0;
      vs_cnt_q      <= 4'd0;
      hsync_q       <= 1'b0;
      vsync_q       <= 1'b0;
      hdisp_q       <= 1'b1;
      vdisp_q       <= 1'b1;
      border_q      <= 1'b0;
      end_scr_q     <= 1'b0;
      end_row_q     <= 1'b0;
      will_adj_q    <= 1'b0;
      adj_mode_q    <= 1'b0;
      v_fired_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      reg_index_q   <= reg_index_d;
      h_total_q     <= h_total_d;
      h_disp_q      <= h_disp_d;
      hsync_pos_q   <= hsync_pos_d;
      hsync_width_q <= hsync_width_d;
      vsync_width_q <= vsync_width_d;
      v_total_q     <= v_total_d;
      v_adjust_q    <= v_adjust_d;
      v_disp_q      <= v_disp_d;
      vsync_pos_q   <= vsync_pos_d;
      skew_q        <= skew_d;
      max_rast_q    <= max_rast_d;
      start_q       <= start_d;
      curs_hi_q     <= curs_hi_d;
      curs_lo_q     <= curs_lo_d;
      addr_q        <= addr_d;
      line_base_q   <= line_base_d;
      rast_q        <= rast_d;
      h_cnt_q       <= h_cnt_d;
      v_cnt_q       <= v_cnt_d;
      hs_cnt_q      <= hs_cnt_d;
      vs_cnt_q      <= vs_cnt_d;
      hsync_q       <= hsync_d;
      vsync_q       <= vsync_d;
      hdisp_q       <= hdisp_d;
      vdisp_q       <= vdisp_d;
      border_q      <= border_d;
      end_scr_q     <= end_scr_d;
      end_row_q     <= end_row_d;
      will_adj_q    <= will_adj_d;
      adj_mode_q    <= adj_mode_d;
      v_fired_q     <= v_fired_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Read data is payload only; it is meaningful while out_valid_q is set.
  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
  end

  // State changes only when a beat is accepted, and an accepted beat always
  // replaces the pending result, so the timing outputs come straight from
  // the state registers.
  assign out_valid_o   = out_valid_q;
  assign rdata_o       = rdata_q;
  assign mem_addr_o    = addr_q;
  assign raster_addr_o = rast_q;
  assign hsync_o       = hsync_q;
  assign vsync_o       = vsync_q;
  assign border_o      = border_q;

endmodule

`default_nettype wire

/* rtl/crtc_checker.sv */
// ----------------------------------------------------------------------------
// crtc_checker - port-level checks for the CRT timing controller
// Watches both channels and the memory and raster address outputs; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crtc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  func_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  rdata_o,
  input wire logic [13:0] mem_addr_o,
  input wire logic [4:0]  raster_addr_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // Every accepted beat yields a result beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_take |=> out_valid_o)
    else $error("accepted beat produced no result");

  // The input side only stalls while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending result");

  // Anything but a read returns zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && (func_i != crtc_pkg::FUNC_READ)) |=> (rdata_o == 8'h00))
    else $error("non-read beat returned data");

  // Timing outputs move only when a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_take |=> ($stable(mem_addr_o) && $stable(raster_addr_o)))
    else $error("timing outputs changed without an accepted beat");

  // A stalled result beat keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(rdata_o)))
    else $error("stalled result changed");

endmodule

bind crt_timing_controller crtc_checker u_crtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .func_i        (func_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .rdata_o       (rdata_o),
  .mem_addr_o    (mem_addr_o),
  .raster_addr_o (raster_addr_o)
);

`default_nettype wire
